// ----- src/sobel_edge_threshold_core_macros.svh -----
// Assertion helpers for the Sobel edge core.
// Each check is enabled in simulation and empty in synthesis.
`ifndef SOBEL_EDGE_THRESHOLD_CORE_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SOBET_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sobel edge core: same-cycle check failed");
`define SOBET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sobel edge core: next-cycle check failed");
`else
`define SOBET_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SOBET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/sobet_pkg.sv -----
package sobet_pkg;

  // Default line store depth.
  localparam int MAX_WIDTH_DEF = 2048;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Register reset values and limits.
  localparam logic [11:0] FRAME_WIDTH_RST    = 12'd640;
  localparam logic [11:0] FRAME_HEIGHT_RST   = 12'd480;
  localparam logic [10:0] EDGE_THRESHOLD_RST = 11'd128;
  localparam logic [11:0] MIN_DIM            = 12'd3;

  // Pixel codes for the edge decision.
  localparam logic [7:0] EDGE_ON  = 8'd255;
  localparam logic [7:0] EDGE_OFF = 8'd0;

  // Result queue depth.
  localparam int RES_FIFO_DEPTH = 8;

  // One result beat.
  typedef struct packed {
    logic [7:0]  edge_pixel;
    logic [10:0] gradient_sum;
    logic [11:0] centre_row;
    logic [10:0] centre_column;
    logic        frame_last;
  } res_t;

  // Position data that travels with a centre through the pipeline.
  typedef struct packed {
    logic [11:0] centre_row;
    logic [10:0] centre_column;
    logic        frame_last;
  } pos_t;

endpackage

// ----- src/sobel_edge_threshold_core.sv -----
// Channel | Direction | Ports                                          | Handshake
// in      | input     | in_pixel_value                                 | in_valid / in_stall
// out     | output    | out_edge_pixel, out_gradient_sum,              | out_valid / out_stall
//         |           | out_centre_row, out_centre_column, out_frame_last |
// cfg     | input     | cfg_index, cfg_data                            | cfg_valid / cfg_ready
//
// One pixel is taken per clock unless in_stall; results cross s1-s3 into the queue.
// The rate is set by the line store: one read and one write port per cycle.
// Synchronous active-low reset restores the registers and empties the pipeline;
// the line store keeps its contents and needs no clearing.
// in_stall rises when the result queue could not hold every pixel in flight.
`include "sobel_edge_threshold_core_macros.svh"

module sobel_edge_threshold_core #(
  parameter int MAX_WIDTH = sobet_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel_value,
  // Result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_edge_pixel,
  output logic [10:0] out_gradient_sum,
  output logic [11:0] out_centre_row,
  output logic [10:0] out_centre_column,
  output logic        out_frame_last,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW    = (CW + 1 > 12) ? CW + 1 : 12;
  localparam int FD    = sobet_pkg::RES_FIFO_DEPTH;
  localparam int PW    = $clog2(FD);
  localparam int NW    = PW + 1;

  // Configuration registers.
  logic [11:0] frame_width_r;
  logic [11:0] frame_height_r;
  logic [10:0] edge_threshold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= sobet_pkg::FRAME_WIDTH_RST;
      frame_height_r   <= sobet_pkg::FRAME_HEIGHT_RST;
      edge_threshold_r <= sobet_pkg::EDGE_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sobet_pkg::cfg_reg_t'(cfg_index))
        sobet_pkg::REG_FRAME_WIDTH:    frame_width_r    <= cfg_data;
        sobet_pkg::REG_FRAME_HEIGHT:   frame_height_r   <= cfg_data;
        sobet_pkg::REG_EDGE_THRESHOLD: edge_threshold_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Effective geometry with out-of-range values clamped.
  logic [WW-1:0] eff_width;
  logic [11:0]   eff_height;

  always_comb begin
    if (frame_width_r < sobet_pkg::MIN_DIM) begin
      eff_width = WW'(sobet_pkg::MIN_DIM);
    end else if (WW'(frame_width_r) > WW'(MAX_WIDTH)) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(frame_width_r);
    end
    eff_height = (frame_height_r < sobet_pkg::MIN_DIM) ? sobet_pkg::MIN_DIM : frame_height_r;
  end

  // Raster counters and the decisions made at the pixel beat.
  logic [CW-1:0] col_cnt_r;
  logic [11:0]   row_cnt_r;
  logic [WW-1:0] col_w;
  logic [WW-1:0] col_inc;
  logic [12:0]   row_inc;
  logic          in_accept;
  logic          emit_now;
  logic          last_now;
  logic [WW-1:0] col_m1;
  sobet_pkg::pos_t pos_now;

  assign in_accept = in_valid && !in_stall;
  assign col_w     = WW'(col_cnt_r);
  assign col_inc   = col_w + WW'(1);
  assign row_inc   = {1'b0, row_cnt_r} + 13'd1;
  assign col_m1    = col_w - WW'(1);

  always_comb begin
    emit_now = (row_cnt_r >= 12'd2) && (col_w >= WW'(2)) &&
               (row_cnt_r < eff_height) && (col_w < eff_width);
    last_now = (row_cnt_r == eff_height - 12'd1) && (col_w == eff_width - WW'(1));
    pos_now.centre_row    = row_cnt_r - 12'd1;
    pos_now.centre_column = col_m1[10:0];
    pos_now.frame_last    = last_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_accept) begin
      if (col_inc >= eff_width) begin
        col_cnt_r <= '0;
        row_cnt_r <= (row_inc >= {1'b0, eff_height}) ? 12'd0 : row_inc[11:0];
      end else begin
        col_cnt_r <= col_inc[CW-1:0];
      end
    end
  end

  // Line store: upper byte holds row r-2, lower byte row r-1, one entry per column.
  // A pixel reads its column at the beat and writes it back in the next cycle.
  // Consecutive pixels always address different columns, so no forwarding is needed.
  logic [15:0]   line_mem [MAX_WIDTH];
  logic [15:0]   mem_rd_r;
  logic          s1_v_r;
  logic          s1_emit_r;
  logic [CW-1:0] s1_addr_r;
  logic [7:0]    s1_pix_r;
  sobet_pkg::pos_t s1_pos_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem_rd_r <= line_mem[col_cnt_r];
    end
    if (s1_v_r) begin
      line_mem[s1_addr_r] <= {mem_rd_r[7:0], s1_pix_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_accept;
    end
    if (in_accept) begin
      s1_emit_r <= emit_now;
      s1_addr_r <= col_cnt_r;
      s1_pix_r  <= in_pixel_value;
      s1_pos_r  <= pos_now;
    end
  end

  // 3x3 window, index row*3 + column, row 0 oldest, column 2 newest.
  logic [7:0] win_r [9];
  logic       s2_v_r;
  sobet_pkg::pos_t s2_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
    if (s1_v_r) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]   <= win_r[k*3+1];
        win_r[k*3+1] <= win_r[k*3+2];
      end
      win_r[2] <= mem_rd_r[15:8];
      win_r[5] <= mem_rd_r[7:0];
      win_r[8] <= s1_pix_r;
      s2_pos_r <= s1_pos_r;
    end
  end

  // Both gradients from the window.
  logic [9:0]         top_sum, bot_sum, lft_sum, rgt_sum;
  logic signed [11:0] gx, gy;

  always_comb begin
    top_sum = 10'(win_r[0]) + {1'b0, win_r[1], 1'b0} + 10'(win_r[2]);
    bot_sum = 10'(win_r[6]) + {1'b0, win_r[7], 1'b0} + 10'(win_r[8]);
    lft_sum = 10'(win_r[0]) + {1'b0, win_r[3], 1'b0} + 10'(win_r[6]);
    rgt_sum = 10'(win_r[2]) + {1'b0, win_r[5], 1'b0} + 10'(win_r[8]);
    gx = $signed({2'b00, bot_sum}) - $signed({2'b00, top_sum});
    gy = $signed({2'b00, rgt_sum}) - $signed({2'b00, lft_sum});
  end

  logic               s3_v_r;
  logic signed [11:0] s3_gx_r, s3_gy_r;
  sobet_pkg::pos_t    s3_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    if (s2_v_r) begin
      s3_gx_r  <= gx;
      s3_gy_r  <= gy;
      s3_pos_r <= s2_pos_r;
    end
  end

  // Magnitude and threshold decision.
  logic [11:0] abs_gx, abs_gy;
  logic [10:0] grad_sum;
  sobet_pkg::res_t res_new;

  always_comb begin
    abs_gx   = s3_gx_r[11] ? 12'(-s3_gx_r) : 12'(s3_gx_r);
    abs_gy   = s3_gy_r[11] ? 12'(-s3_gy_r) : 12'(s3_gy_r);
    grad_sum = abs_gx[10:0] + abs_gy[10:0];
    res_new.edge_pixel    = (grad_sum >= edge_threshold_r) ? sobet_pkg::EDGE_ON
                                                           : sobet_pkg::EDGE_OFF;
    res_new.gradient_sum  = grad_sum;
    res_new.centre_row    = s3_pos_r.centre_row;
    res_new.centre_column = s3_pos_r.centre_column;
    res_new.frame_last    = s3_pos_r.frame_last;
  end

  // Result queue; input stalls once it could not absorb every pixel in flight.
  sobet_pkg::res_t fifo_mem [FD];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]   fifo_cnt_r;
  logic [NW-1:0]   occupancy;
  logic            fifo_push, fifo_pop;
  sobet_pkg::res_t res_head;

  assign fifo_push = s3_v_r;
  assign fifo_pop  = out_valid && !out_stall;
  assign occupancy = fifo_cnt_r + NW'(s1_v_r) + NW'(s2_v_r) + NW'(s3_v_r);
  assign in_stall  = (occupancy >= NW'(FD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (fifo_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + NW'(fifo_push) - NW'(fifo_pop);
    end
    if (fifo_push) begin
      fifo_mem[wr_ptr_r] <= res_new;
    end
  end

  assign res_head          = fifo_mem[rd_ptr_r];
  assign out_valid         = (fifo_cnt_r != '0);
  assign out_edge_pixel    = res_head.edge_pixel;
  assign out_gradient_sum  = res_head.gradient_sum;
  assign out_centre_row    = res_head.centre_row;
  assign out_centre_column = res_head.centre_column;
  assign out_frame_last    = res_head.frame_last;

  // The queue never takes a result it has no room for.
  `SOBET_ASSERT_IMPLY(a_fifo_no_overflow, clk, rst_n, fifo_push, (fifo_cnt_r < NW'(FD)) || fifo_pop)
  // A new read never hits the column being written back.
  `SOBET_ASSERT_IMPLY(a_no_rmw_collision, clk, rst_n, in_accept && s1_v_r, col_cnt_r != s1_addr_r)
  // Every accepted pixel reaches the write-back stage next cycle.
  `SOBET_ASSERT_NEXT(a_accept_reaches_s1, clk, rst_n, in_accept, s1_v_r)

endmodule

// ----- sim/sobel_edge_threshold_core_tb.sv -----
`timescale 1ns / 1ps

module sobel_edge_threshold_core_tb;

  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int TOTAL_PIXELS = 1200;

  // Index past the end of the register list; writes to it must be ignored.
  localparam logic [1:0] REG_NONE = 2'd3;

  // Directed 3x3 frames, first pixel in the top byte.
  // Steepest possible ramp: gradient sum 1530 with both differences positive.
  localparam logic [71:0] STEEP_RISE = {8'd0, 8'd0, 8'd77, 8'd0, 8'd200, 8'd255,
                                        8'd13, 8'd255, 8'd255};
  // Its complement: same sum with both differences negative.
  localparam logic [71:0] STEEP_FALL = {8'd255, 8'd255, 8'd178, 8'd255, 8'd55, 8'd0,
                                        8'd242, 8'd0, 8'd0};
  // Flat white frame: zero gradient.
  localparam logic [71:0] FLAT_WHITE = {9{8'd255}};

  typedef enum logic [1:0] {
    FILL_NOISE,
    FILL_EXTREME,
    FILL_FLAT
  } fill_t;

  // Tracks the pixel stream, predicts each interior result and checks the outputs.
  class edge_scoreboard;
    logic [11:0]     width_reg;
    logic [11:0]     height_reg;
    logic [10:0]     thresh_reg;
    logic [7:0]      upper_row [sobet_pkg::MAX_WIDTH_DEF];
    logic [7:0]      lower_row [sobet_pkg::MAX_WIDTH_DEF];
    int              win [3][3];
    int unsigned     col;
    int unsigned     row;
    sobet_pkg::res_t pending_centres [$];
    int              pixels;
    int              results;
    int              edges;
    int              frames;
    int              writes;
    int              errors;

    function new();
      width_reg  = sobet_pkg::FRAME_WIDTH_RST;
      height_reg = sobet_pkg::FRAME_HEIGHT_RST;
      thresh_reg = sobet_pkg::EDGE_THRESHOLD_RST;
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = 0;
      col     = 0;
      row     = 0;
      pixels  = 0;
      results = 0;
      edges   = 0;
      frames  = 0;
      writes  = 0;
      errors  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [11:0] data);
      writes++;
      case (idx)
        sobet_pkg::REG_FRAME_WIDTH: begin
          width_reg = data;
        end
        sobet_pkg::REG_FRAME_HEIGHT: begin
          height_reg = data;
        end
        sobet_pkg::REG_EDGE_THRESHOLD: begin
          thresh_reg = data[10:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Shift the window, update the line stores and queue a result for interior centres.
    function void take_pixel(logic [7:0] pix);
      int unsigned     w;
      int unsigned     h;
      int              k;
      int              vert_diff;
      int              horiz_diff;
      int              mag;
      sobet_pkg::res_t want;
      w = (width_reg < sobet_pkg::MIN_DIM) ? sobet_pkg::MIN_DIM :
          (width_reg > sobet_pkg::MAX_WIDTH_DEF) ? sobet_pkg::MAX_WIDTH_DEF : width_reg;
      h = (height_reg < sobet_pkg::MIN_DIM) ? sobet_pkg::MIN_DIM : height_reg;
      pixels++;
      for (k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = upper_row[col];
      win[1][2] = lower_row[col];
      win[2][2] = pix;
      upper_row[col] = lower_row[col];
      lower_row[col] = pix;

      if (row >= 2 && col >= 2 && row < h && col < w) begin
        vert_diff  = (win[2][0] + 2 * win[2][1] + win[2][2])
                   - (win[0][0] + 2 * win[0][1] + win[0][2]);
        horiz_diff = (win[0][2] + 2 * win[1][2] + win[2][2])
                   - (win[0][0] + 2 * win[1][0] + win[2][0]);
        mag = (vert_diff < 0 ? -vert_diff : vert_diff)
            + (horiz_diff < 0 ? -horiz_diff : horiz_diff);
        want.edge_pixel    = (mag >= thresh_reg) ? sobet_pkg::EDGE_ON : sobet_pkg::EDGE_OFF;
        want.gradient_sum  = 11'(mag);
        want.centre_row    = 12'(row - 1);
        want.centre_column = 11'(col - 1);
        want.frame_last    = (row == h - 1) && (col == w - 1);
        pending_centres.push_back(want);
      end

      // Advance the raster position; counters past a shrunken limit wrap here.
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(sobet_pkg::res_t got);
      sobet_pkg::res_t want;
      if (pending_centres.size() == 0) begin
        $error("unexpected result beat at row %0d, column %0d",
               got.centre_row, got.centre_column);
        errors++;
        return;
      end
      want = pending_centres.pop_front();
      results++;
      if (want.edge_pixel == sobet_pkg::EDGE_ON) edges++;
      if (want.frame_last) frames++;
      compare_field("edge_pixel", want.edge_pixel, got.edge_pixel);
      compare_field("gradient_sum", want.gradient_sum, got.gradient_sum);
      compare_field("centre_row", want.centre_row, got.centre_row);
      compare_field("centre_column", want.centre_column, got.centre_column);
      compare_field("frame_last", want.frame_last, got.frame_last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_pixel_value;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_edge_pixel;
  logic [10:0] out_gradient_sum;
  logic [11:0] out_centre_row;
  logic [10:0] out_centre_column;
  logic        out_frame_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  edge_scoreboard sb;
  bit             in_idle;
  bit             out_idle;
  int             flat_base;

  sobel_edge_threshold_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel_value    (in_pixel_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_edge_pixel    (out_edge_pixel),
    .out_gradient_sum  (out_gradient_sum),
    .out_centre_row    (out_centre_row),
    .out_centre_column (out_centre_column),
    .out_frame_last    (out_frame_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Pixel beat with an optional random gap in front of it.
  task automatic send_pixel(input logic [7:0] pix);
    int gap;
    gap = in_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= pix;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.take_pixel(pix);
  endtask

  function automatic logic [7:0] next_pixel(fill_t mode);
    int v;
    case (mode)
      FILL_EXTREME: begin
        v = $urandom_range(0, 1) ? 255 : 0;
      end
      FILL_FLAT: begin
        v = flat_base + $urandom_range(0, 6) - 3;
        v = (v < 0) ? 0 : (v > 255) ? 255 : v;
      end
      default: begin
        v = $urandom_range(0, 255);
      end
    endcase
    return 8'(v);
  endfunction

  task automatic send_pixels(input int count, input fill_t mode);
    repeat (count) send_pixel(next_pixel(mode));
  endtask

  // Feed pixels until the raster position is back at the top-left corner.
  task automatic run_to_frame_end(input fill_t mode);
    do send_pixel(next_pixel(mode));
    while (sb.col != 0 || sb.row != 0);
  endtask

  task automatic send_tile(input logic [71:0] tile);
    for (int i = 8; i >= 0; i--) send_pixel(tile[8 * i +: 8]);
  endtask

  // Let every expected result drain, then give the pipeline time to settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_centres.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write width, height and threshold; optionally slip in a write to an unused index.
  task automatic program_regs(input logic [11:0] w, input logic [11:0] h,
                              input logic [11:0] thresh, input bit stray);
    logic [1:0]  idx_list [4];
    logic [11:0] val_list [4];
    int          n;
    n = 0;
    idx_list[n] = sobet_pkg::REG_FRAME_WIDTH;
    val_list[n] = w;
    n++;
    if (stray) begin
      idx_list[n] = REG_NONE;
      val_list[n] = 12'($urandom_range(0, 4095));
      n++;
    end
    idx_list[n] = sobet_pkg::REG_FRAME_HEIGHT;
    val_list[n] = h;
    n++;
    idx_list[n] = sobet_pkg::REG_EDGE_THRESHOLD;
    val_list[n] = thresh;
    n++;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.write_reg(idx_list[i], val_list[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stall before each beat, then take whatever arrives.
  initial begin : result_sink
    int              stall_len;
    sobet_pkg::res_t got;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall_len = out_idle ? $urandom_range(0, 19) : 0;
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.edge_pixel    = out_edge_pixel;
      got.gradient_sum  = out_gradient_sum;
      got.centre_row    = out_centre_row;
      got.centre_column = out_centre_column;
      got.frame_last    = out_frame_last;
      sb.match_result(got);
    end
  end

  // Ends the run if no beat moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int          phase;
    int          frame_total;
    int          pick;
    logic [11:0] w;
    logic [11:0] h;
    logic [11:0] thresh;
    fill_t       mode;

    sb = new();
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_pixel_value <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= sobet_pkg::REG_FRAME_WIDTH;
    cfg_data       <= '0;
    in_idle  = 1'b0;
    out_idle = 1'b0;
    flat_base = 128;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: degenerate geometry, sum exactly at the threshold, unreachable
    // threshold with negative differences, zero threshold on a flat frame.
    in_idle  = $urandom_range(0, 1);
    out_idle = $urandom_range(0, 1);
    program_regs(12'd0, 12'd0, 12'd1530, 1'b1);
    send_tile(STEEP_RISE);
    wait_idle();
    program_regs(12'd2, 12'd2, 12'hFFF, 1'b0);
    send_tile(STEEP_FALL);
    wait_idle();
    program_regs(12'd1, 12'd1, 12'd0, 1'b0);
    send_tile(FLAT_WHITE);
    wait_idle();

    // Width shrinks mid-frame below the current column: the column wraps.
    program_regs(12'd8, 12'd8, 12'($urandom_range(0, 800)), 1'b0);
    send_pixels(21, FILL_NOISE);
    wait_idle();
    program_regs(12'd3, 12'd8, 12'($urandom_range(0, 800)), 1'b0);
    run_to_frame_end(FILL_NOISE);
    wait_idle();

    // Height shrinks mid-frame below the current row: the row wraps.
    program_regs(12'd5, 12'd8, 12'($urandom_range(0, 800)), 1'b0);
    send_pixels(22, FILL_NOISE);
    wait_idle();
    program_regs(12'd5, 12'd3, 12'($urandom_range(0, 800)), 1'b0);
    run_to_frame_end(FILL_NOISE);
    wait_idle();

    // Random phases of small frames until the pixel budget is spent.
    phase = 0;
    while (phase < 6 || sb.pixels < TOTAL_PIXELS) begin
      w = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2))
                                      : 12'($urandom_range(3, 16));
      h = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 2))
                                      : 12'($urandom_range(3, 10));
      pick = $urandom_range(0, 7);
      if (pick == 0)
        thresh = 12'd0;
      else if (pick == 1)
        thresh = 12'($urandom_range(2041, 4095));
      else
        thresh = 12'($urandom_range(0, 1000));

      in_idle  = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      program_regs(w, h, thresh, $urandom_range(0, 3) == 0);
      frame_total = $urandom_range(1, 2);
      repeat (frame_total) begin
        mode      = fill_t'($urandom_range(0, 2));
        flat_base = $urandom_range(0, 255);
        run_to_frame_end(mode);
      end
      wait_idle();
      phase++;
    end

    if (sb.pending_centres.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_centres.size());
      sb.errors++;
    end
    $display("covered %0d pixel beats in %0d frames and %0d register writes",
             sb.pixels, sb.frames, sb.writes);
    $display("checked %0d results, %0d of them marked as edges", sb.results, sb.edges);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- sobel_edge_threshold_core.f -----
+incdir+src
src/sobet_pkg.sv
src/sobel_edge_threshold_core.sv
sim/sobel_edge_threshold_core_tb.sv
